@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

@@ hdl/klm_pkg.sv @@
// Package for the key lock manager: function and status codes, FSM states.
// No dependencies.
package klm_pkg;
  typedef enum logic [2:0] {
    FN_REGISTER = 3'd0, FN_GET = 3'd1, FN_SET = 3'd2, FN_STORE = 3'd3, FN_ABORT = 3'd4
  } func_t;
  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_BLOCKED = 3'd1, ST_ABORTED = 3'd2, ST_UNKNOWN = 3'd3,
    ST_TABLE_FULL = 3'd4, ST_QUEUE_FULL = 3'd5
  } status_t;
  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_SRCH_WAIT, S_DECIDE, S_QREAD, S_QWAIT, S_HANDOFF,
    S_PURGE_RD, S_PURGE_WAIT, S_PURGE_WR, S_PURGE_END, S_DONE
  } state_t;
endpackage

@@ hdl/klm_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module klm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/key_lock_manager.sv @@
// Key lock manager: lock table, per-key FIFO wait queues, process registry.
// Register, undefined codes and unknown callers finish without a key search; get/set/store
// search the used slots in order for the key, and an abort purge removes the caller
// from every wait queue, entry by entry.
// One item at a time: the next input can transfer in the cycle after the result transfer.
// Synchronous active-low reset clears valid bits, counts and heads; memories are not.
module key_lock_manager #(
  parameter int KEY_SLOTS     = 16,
  parameter int WAIT_DEPTH    = 8,
  parameter int PROCESS_COUNT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_func,
  input  logic [5:0] in_process_id,
  input  logic [31:0] in_key_id,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic       out_handoff_valid,
  output logic [5:0] out_handoff_process
);
  localparam int SW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int QW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int CW = $clog2(WAIT_DEPTH + 1);
  localparam int AW = $clog2(KEY_SLOTS * WAIT_DEPTH) > 0 ? $clog2(KEY_SLOTS * WAIT_DEPTH) : 1;
  localparam int SC = $clog2(KEY_SLOTS + 1);

  klm_pkg::state_t state_r, state_nxt;

  // Request registers
  logic [2:0]  func_r;
  logic [5:0]  pid_r;
  logic [31:0] key_r;
  // Control registers
  logic [SC-1:0] scan_r;      // search index / purge slot
  logic          found_r;
  logic [SW-1:0] slot_r;
  logic [CW-1:0] idx_r, kept_r;
  logic [2:0]    status_r;
  logic          hv_r;
  logic [5:0]    hp_r;
  // Flip-flop state
  logic [KEY_SLOTS-1:0]     owner_valid_r;
  logic [QW-1:0]            head_r  [KEY_SLOTS];
  logic [CW-1:0]            count_r [KEY_SLOTS];
  logic [PROCESS_COUNT-1:0] known_r;
  logic [SC-1:0]            free_cnt_r;  // slots are filled in order

  // Memories
  logic          tag_we, own_we, q_we;
  logic [SW-1:0] tag_ra, own_ra, own_wa;
  logic [31:0]   tag_rd;
  logic [5:0]    own_rd, own_wd, q_wd, q_rd;
  logic [AW-1:0] q_wa, q_ra;

  klm_ram #(.WIDTH(32), .DEPTH(KEY_SLOTS)) u_tag (
    .clk, .we(tag_we), .waddr(free_cnt_r[SW-1:0]), .wdata(key_r),
    .raddr(tag_ra), .rdata(tag_rd));
  klm_ram #(.WIDTH(6), .DEPTH(KEY_SLOTS)) u_own (
    .clk, .we(own_we), .waddr(own_wa), .wdata(own_wd),
    .raddr(own_ra), .rdata(own_rd));
  klm_ram #(.WIDTH(6), .DEPTH(KEY_SLOTS * WAIT_DEPTH)) u_q (
    .clk, .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

  logic known_w;
  assign known_w = (32'(pid_r) < 32'(PROCESS_COUNT)) && known_r[pid_r[$clog2(PROCESS_COUNT)-1:0]];

  function automatic logic [AW-1:0] qaddr(input logic [SW-1:0] s, input logic [QW-1:0] h,
                                          input logic [CW-1:0] off);
    logic [QW:0] p;
    p = {1'b0, h} + (QW+1)'(off);
    if (p >= (QW+1)'(WAIT_DEPTH)) p = p - (QW+1)'(WAIT_DEPTH);
    return AW'(32'(s) * WAIT_DEPTH + 32'(p));
  endfunction

  logic [SW-1:0] scan_s;
  assign scan_s = scan_r[SW-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      klm_pkg::S_IDLE: if (in_valid) state_nxt = klm_pkg::S_DECIDE;
      klm_pkg::S_DECIDE: begin
        if (func_r == klm_pkg::FN_REGISTER || func_r > klm_pkg::FN_ABORT || !known_w)
          state_nxt = klm_pkg::S_DONE;
        else if (func_r == klm_pkg::FN_ABORT)
          state_nxt = (KEY_SLOTS > 0) ? klm_pkg::S_PURGE_RD : klm_pkg::S_DONE;
        else state_nxt = klm_pkg::S_SEARCH;
      end
      klm_pkg::S_SEARCH: state_nxt = (scan_r >= free_cnt_r) ? klm_pkg::S_QREAD
                                                            : klm_pkg::S_SRCH_WAIT;
      klm_pkg::S_SRCH_WAIT: state_nxt = (tag_rd == key_r) ? klm_pkg::S_QREAD
                                                          : klm_pkg::S_SEARCH;
      klm_pkg::S_QREAD: state_nxt = klm_pkg::S_QWAIT;
      klm_pkg::S_QWAIT: state_nxt = klm_pkg::S_HANDOFF;
      klm_pkg::S_HANDOFF: state_nxt = (status_r == klm_pkg::ST_ABORTED)
                                      ? klm_pkg::S_PURGE_RD : klm_pkg::S_DONE;
      klm_pkg::S_PURGE_RD: state_nxt = (idx_r >= count_r[scan_s]) ? klm_pkg::S_PURGE_END
                                                                  : klm_pkg::S_PURGE_WAIT;
      klm_pkg::S_PURGE_WAIT: state_nxt = klm_pkg::S_PURGE_WR;
      klm_pkg::S_PURGE_WR: state_nxt = klm_pkg::S_PURGE_RD;
      klm_pkg::S_PURGE_END: state_nxt = (scan_r == SC'(KEY_SLOTS - 1)) ? klm_pkg::S_DONE
                                                                       : klm_pkg::S_PURGE_RD;
      klm_pkg::S_DONE: if (!out_stall) state_nxt = klm_pkg::S_IDLE;
      default: state_nxt = klm_pkg::S_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    tag_we = 1'b0; own_we = 1'b0; q_we = 1'b0;
    tag_ra = scan_s; own_ra = slot_r; own_wa = slot_r; own_wd = pid_r;
    q_wa = qaddr(slot_r, head_r[slot_r], count_r[slot_r]); q_wd = pid_r;
    q_ra = qaddr(slot_r, head_r[slot_r], '0);
    case (state_r)
      klm_pkg::S_SEARCH: own_ra = scan_s;
      klm_pkg::S_SRCH_WAIT: own_ra = scan_s;
      klm_pkg::S_PURGE_RD: q_ra = qaddr(scan_s, head_r[scan_s], idx_r);
      // keep the entry address so the read data is still there at write-back
      klm_pkg::S_PURGE_WAIT: q_ra = qaddr(scan_s, head_r[scan_s], idx_r);
      klm_pkg::S_PURGE_WR: begin
        q_we = (q_rd != pid_r);
        q_wa = qaddr(scan_s, head_r[scan_s], kept_r);
        q_wd = q_rd;
      end
      klm_pkg::S_HANDOFF: begin
        if (func_r == klm_pkg::FN_GET && !found_r && status_r == klm_pkg::ST_OK) begin
          tag_we = 1'b1; own_we = 1'b1; own_wa = free_cnt_r[SW-1:0];
        end else if (func_r == klm_pkg::FN_GET && found_r && !owner_valid_r[slot_r]) begin
          own_we = 1'b1;
        end else if (status_r == klm_pkg::ST_BLOCKED) begin
          q_we = 1'b1;
        end else if (hv_r) begin
          own_we = 1'b1; own_wd = hp_r;
        end
      end
      default: ;
    endcase
  end

  // Datapath and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= klm_pkg::S_IDLE;
      owner_valid_r <= '0; known_r <= '0; free_cnt_r <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        head_r[i] <= '0; count_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        klm_pkg::S_IDLE: if (in_valid) begin
          func_r <= in_func; pid_r <= in_process_id; key_r <= in_key_id;
          status_r <= klm_pkg::ST_OK; hv_r <= 1'b0; hp_r <= '0;
          scan_r <= '0; found_r <= 1'b0; idx_r <= '0; kept_r <= '0;
        end
        klm_pkg::S_DECIDE: begin
          if (func_r == klm_pkg::FN_REGISTER) begin
            if (32'(pid_r) < 32'(PROCESS_COUNT))
              known_r[pid_r[$clog2(PROCESS_COUNT)-1:0]] <= 1'b1;
            else status_r <= klm_pkg::ST_UNKNOWN;
          end else if (func_r <= klm_pkg::FN_ABORT && !known_w) begin
            status_r <= klm_pkg::ST_UNKNOWN;
          end else if (func_r == klm_pkg::FN_ABORT) begin
            known_r[pid_r[$clog2(PROCESS_COUNT)-1:0]] <= 1'b0;
            status_r <= klm_pkg::ST_ABORTED;
          end
        end
        klm_pkg::S_SRCH_WAIT: begin
          if (tag_rd == key_r) begin
            found_r <= 1'b1; slot_r <= scan_s;
          end else scan_r <= scan_r + 1'b1;
        end
        klm_pkg::S_QWAIT: begin
          // own_rd holds owner of slot_r (read in S_QREAD); q_rd holds head
          if (func_r == klm_pkg::FN_GET) begin
            if (!found_r) begin
              if (free_cnt_r == SC'(KEY_SLOTS)) status_r <= klm_pkg::ST_TABLE_FULL;
            end else if (owner_valid_r[slot_r] && own_rd != pid_r) begin
              if (count_r[slot_r] >= CW'(WAIT_DEPTH)) status_r <= klm_pkg::ST_QUEUE_FULL;
              else status_r <= klm_pkg::ST_BLOCKED;
            end
          end else if (!found_r || !owner_valid_r[slot_r] || own_rd != pid_r) begin
            known_r[pid_r[$clog2(PROCESS_COUNT)-1:0]] <= 1'b0;
            status_r <= klm_pkg::ST_ABORTED;
          end else if (func_r == klm_pkg::FN_STORE && count_r[slot_r] != '0) begin
            hv_r <= 1'b1; hp_r <= q_rd;
          end
        end
        klm_pkg::S_HANDOFF: begin
          scan_r <= '0;
          if (func_r == klm_pkg::FN_GET && !found_r && status_r == klm_pkg::ST_OK) begin
            owner_valid_r[free_cnt_r[SW-1:0]] <= 1'b1;
            head_r[free_cnt_r[SW-1:0]] <= '0; count_r[free_cnt_r[SW-1:0]] <= '0;
            free_cnt_r <= free_cnt_r + 1'b1;
          end else if (func_r == klm_pkg::FN_GET && found_r) begin
            owner_valid_r[slot_r] <= 1'b1;
            if (status_r == klm_pkg::ST_BLOCKED) count_r[slot_r] <= count_r[slot_r] + 1'b1;
          end else if (func_r == klm_pkg::FN_STORE && status_r == klm_pkg::ST_OK) begin
            owner_valid_r[slot_r] <= hv_r;
            if (hv_r) begin
              head_r[slot_r] <= (32'(head_r[slot_r]) + 1 == WAIT_DEPTH) ? '0
                                : head_r[slot_r] + 1'b1;
              count_r[slot_r] <= count_r[slot_r] - 1'b1;
            end
          end
        end
        klm_pkg::S_PURGE_WR: begin
          idx_r <= idx_r + 1'b1;
          if (q_rd != pid_r) kept_r <= kept_r + 1'b1;
        end
        klm_pkg::S_PURGE_END: begin
          count_r[scan_s] <= kept_r;
          idx_r <= '0; kept_r <= '0;
          scan_r <= scan_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign in_stall            = (state_r != klm_pkg::S_IDLE);
  assign out_valid           = (state_r == klm_pkg::S_DONE);
  assign out_status          = status_r;
  assign out_handoff_valid   = hv_r;
  assign out_handoff_process = hp_r;
endmodule

@@ hdl/klm_checker.sv @@
// Port-level checker for the key lock manager, bound to the top level.
// Depends on assert_macros.svh and klm_pkg.
`include "assert_macros.svh"
module klm_port_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_status,
  input logic       out_handoff_valid
);
  `CHK_IMPL(a_one_at_a_time, clk, rst_n, out_valid, in_stall)
  `CHK_IMPL(a_status_range, clk, rst_n, out_valid, out_status <= klm_pkg::ST_QUEUE_FULL)
  `CHK_IMPL(a_handoff_ok, clk, rst_n, out_valid && out_handoff_valid,
            out_status == klm_pkg::ST_OK)
  `CHK_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall)
  // a stalled result stays offered
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
endmodule

bind key_lock_manager klm_port_checker u_klm_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_status,
  .out_handoff_valid);
